@@ hw/rtl/work_byte_alu_branch_core_macros.svh @@
`ifndef WORK_BYTE_ALU_BRANCH_CORE_MACROS_SVH
`define WORK_BYTE_ALU_BRANCH_CORE_MACROS_SVH

// checks sampled on clk_i, quiet while rst_ni is low
`define WBAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checks that must also hold while in reset
`define WBAB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/wbab_pkg.sv @@
`default_nettype none

package wbab_pkg;

  localparam int unsigned WORK_BYTE_COUNT_DEF = 16;
  localparam int unsigned REQ_TYPE_W          = 8;
  localparam int unsigned TARGET_W            = 4;
  localparam int unsigned BYTE_W              = 8;
  localparam int unsigned OUTCOME_W           = 2;

  typedef enum logic [REQ_TYPE_W-1:0] {
    OP_SET_IMM = 8'd0,
    OP_ADD_IMM = 8'd1,
    OP_SUB_IMM = 8'd2,
    OP_SET_REG = 8'd3,
    OP_ADD_REG = 8'd4,
    OP_SUB_REG = 8'd5,
    OP_EQ_IMM  = 8'd6,
    OP_NE_IMM  = 8'd7,
    OP_GT_IMM  = 8'd8,
    OP_GE_IMM  = 8'd9,
    OP_LE_IMM  = 8'd10,
    OP_LT_IMM  = 8'd11,
    OP_EQ_REG  = 8'd12,
    OP_NE_REG  = 8'd13,
    OP_GT_REG  = 8'd14,
    OP_GE_REG  = 8'd15,
    OP_LE_REG  = 8'd16,
    OP_LT_REG  = 8'd17
  } op_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_WRITTEN = 2'd0,
    OUT_JUMP    = 2'd1,
    OUT_SKIP    = 2'd2,
    OUT_UNKNOWN = 2'd3
  } outcome_e;

  typedef struct packed {
    logic              we;
    outcome_e          outcome;
    logic [BYTE_W-1:0] value;
  } alu_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/wbab_if.sv @@
`default_nettype none

interface wbab_req_if;
  import wbab_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [TARGET_W-1:0]   target_index;
  logic [BYTE_W-1:0]     operand;

  modport source (output valid, req_type, target_index, operand, input ready);
  modport sink   (input valid, req_type, target_index, operand, output ready);
endinterface

interface wbab_rsp_if;
  import wbab_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OUTCOME_W-1:0] outcome;
  logic [BYTE_W-1:0]    byte_value;

  modport source (output valid, outcome, byte_value, input ready);
  modport sink   (input valid, outcome, byte_value, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/wbab_ram.sv @@
`default_nettype none

module wbab_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

@@ hw/rtl/wbab_alu.sv @@
`default_nettype none

module wbab_alu (
  input  logic [wbab_pkg::REQ_TYPE_W-1:0] req_type_i,
  input  logic [wbab_pkg::BYTE_W-1:0]     cur_i,
  input  logic [wbab_pkg::BYTE_W-1:0]     imm_i,
  input  logic [wbab_pkg::BYTE_W-1:0]     named_i,
  output wbab_pkg::alu_res_t              res_o
);
  import wbab_pkg::*;

  op_e               op;
  logic              use_named;
  logic [BYTE_W-1:0] rhs;

  assign op        = op_e'(req_type_i);
  assign use_named = op inside {[OP_SET_REG:OP_SUB_REG], [OP_EQ_REG:OP_LT_REG]};
  assign rhs       = use_named ? named_i : imm_i;

  always_comb begin
    res_o.we      = 1'b0;
    res_o.outcome = OUT_UNKNOWN;
    res_o.value   = cur_i;
    case (op)
      OP_SET_IMM, OP_SET_REG: begin
        res_o.we      = 1'b1;
        res_o.outcome = OUT_WRITTEN;
        res_o.value   = rhs;
      end
      OP_ADD_IMM, OP_ADD_REG: begin
        res_o.we      = 1'b1;
        res_o.outcome = OUT_WRITTEN;
        res_o.value   = cur_i + rhs;
      end
      OP_SUB_IMM, OP_SUB_REG: begin
        res_o.we      = 1'b1;
        res_o.outcome = OUT_WRITTEN;
        res_o.value   = cur_i - rhs;
      end
      OP_EQ_IMM, OP_EQ_REG: res_o.outcome = (cur_i == rhs) ? OUT_JUMP : OUT_SKIP;
      OP_NE_IMM, OP_NE_REG: res_o.outcome = (cur_i != rhs) ? OUT_JUMP : OUT_SKIP;
      OP_GT_IMM, OP_GT_REG: res_o.outcome = (cur_i >  rhs) ? OUT_JUMP : OUT_SKIP;
      OP_GE_IMM, OP_GE_REG: res_o.outcome = (cur_i >= rhs) ? OUT_JUMP : OUT_SKIP;
      OP_LE_IMM, OP_LE_REG: res_o.outcome = (cur_i <= rhs) ? OUT_JUMP : OUT_SKIP;
      OP_LT_IMM, OP_LT_REG: res_o.outcome = (cur_i <  rhs) ? OUT_JUMP : OUT_SKIP;
      default: res_o.outcome = OUT_UNKNOWN;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/work_byte_alu_branch_core.sv @@
// Work-byte command unit: each request applies one command (set, add or subtract an immediate
// or another work byte, or an unsigned compare against one) to a file of 8-bit work bytes and
// returns one response with the outcome and the target byte after the command. One request is
// taken every cycle while the response side does not stall. At the accepting edge the read stage
// registers the request and the two-read-port register file latches the target and operand
// bytes; the read stage computes the result, writes it back and loads the output register as
// it advances; the byte written by the previous command is forwarded so back-to-back commands
// see it. Bytes at or beyond the configured count read as zero and are never written. Reset
// clears the file at once through per-byte valid flags, so no clearing pass follows reset.
`default_nettype none

`include "work_byte_alu_branch_core_macros.svh"

module work_byte_alu_branch_core #(
  parameter int unsigned WORK_BYTE_COUNT = wbab_pkg::WORK_BYTE_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wbab_req_if.sink   req_i,
  wbab_rsp_if.source rsp_o
);
  import wbab_pkg::*;

  // only bytes a target index can reach are ever written
  localparam int unsigned TARGET_SPAN = 2 ** TARGET_W;
  localparam int unsigned STORE_DEPTH =
    (WORK_BYTE_COUNT < TARGET_SPAN) ? WORK_BYTE_COUNT : TARGET_SPAN;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  logic                  req_acc;
  logic                  s1_adv;
  logic                  tgt_inr_d;
  logic                  opd_inr_d;
  logic [ADDR_W-1:0]     tgt_addr_d;
  logic [ADDR_W-1:0]     opd_addr_d;

  logic                  s1_vld_q;
  logic [REQ_TYPE_W-1:0] s1_req_type_q;
  logic [BYTE_W-1:0]     s1_operand_q;
  logic [ADDR_W-1:0]     s1_tgt_addr_q;
  logic [ADDR_W-1:0]     s1_opd_addr_q;
  logic                  s1_tgt_inr_q;
  logic                  s1_opd_inr_q;
  logic                  s1_tgt_ok_q;
  logic                  s1_opd_ok_q;

  logic [STORE_DEPTH-1:0] valid_q;
  logic                   fwd_vld_q;
  logic [ADDR_W-1:0]      fwd_addr_q;
  logic [BYTE_W-1:0]      fwd_data_q;

  logic [BYTE_W-1:0]     rd_tgt;
  logic [BYTE_W-1:0]     rd_opd;
  logic [BYTE_W-1:0]     cur;
  logic [BYTE_W-1:0]     named;
  alu_res_t              alu_res;
  logic                  wr_en;
  logic [BYTE_W-1:0]     byte_value_d;

  logic                  out_vld_q;
  outcome_e              out_outcome_q;
  logic [BYTE_W-1:0]     out_value_q;

  assign s1_adv      = !out_vld_q || rsp_o.ready;
  assign req_i.ready = !s1_vld_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  assign tgt_inr_d  = 32'(req_i.target_index) < STORE_DEPTH;
  assign opd_inr_d  = 32'(req_i.operand) < STORE_DEPTH;
  assign tgt_addr_d = req_i.target_index[ADDR_W-1:0];
  assign opd_addr_d = req_i.operand[ADDR_W-1:0];

  wbab_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (s1_tgt_addr_q),
    .wdata_i   (alu_res.value),
    .re_i      (req_acc),
    .raddr_a_i (tgt_addr_d),
    .raddr_b_i (opd_addr_d),
    .rdata_a_o (rd_tgt),
    .rdata_b_o (rd_opd)
  );

  // read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_req_type_q <= req_i.req_type;
      s1_operand_q  <= req_i.operand;
      s1_tgt_addr_q <= tgt_addr_d;
      s1_opd_addr_q <= opd_addr_d;
      s1_tgt_inr_q  <= tgt_inr_d;
      s1_opd_inr_q  <= opd_inr_d;
      s1_tgt_ok_q   <= tgt_inr_d ? valid_q[tgt_addr_d] : 1'b0;
      s1_opd_ok_q   <= opd_inr_d ? valid_q[opd_addr_d] : 1'b0;
    end
  end

  // forward the last write, which may land on the same edge as the read
  always_comb begin
    cur = '0;
    if (s1_tgt_inr_q) begin
      if (fwd_vld_q && (fwd_addr_q == s1_tgt_addr_q)) begin
        cur = fwd_data_q;
      end else if (s1_tgt_ok_q) begin
        cur = rd_tgt;
      end
    end
    named = '0;
    if (s1_opd_inr_q) begin
      if (fwd_vld_q && (fwd_addr_q == s1_opd_addr_q)) begin
        named = fwd_data_q;
      end else if (s1_opd_ok_q) begin
        named = rd_opd;
      end
    end
  end

  wbab_alu u_alu (
    .req_type_i (s1_req_type_q),
    .cur_i      (cur),
    .imm_i      (s1_operand_q),
    .named_i    (named),
    .res_o      (alu_res)
  );

  assign wr_en        = s1_vld_q && s1_adv && alu_res.we && s1_tgt_inr_q;
  assign byte_value_d = (alu_res.we && !s1_tgt_inr_q) ? '0 : alu_res.value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      fwd_vld_q <= 1'b0;
    end else if (wr_en) begin
      valid_q[s1_tgt_addr_q] <= 1'b1;
      fwd_vld_q              <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fwd_addr_q <= s1_tgt_addr_q;
      fwd_data_q <= alu_res.value;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_outcome_q <= alu_res.outcome;
      out_value_q   <= byte_value_d;
    end
  end

  assign rsp_o.valid      = out_vld_q;
  assign rsp_o.outcome    = out_outcome_q;
  assign rsp_o.byte_value = out_value_q;

  `WBAB_ASSERT_RST(a_reset_empty, !rst_ni |=> (!out_vld_q && !s1_vld_q),
                   "pipeline not empty in reset")
  `WBAB_ASSERT(a_adv_fills_out, (s1_vld_q && s1_adv) |=> out_vld_q, "transaction lost at output")
  `WBAB_ASSERT(a_wr_sets_valid, wr_en |=> valid_q[$past(s1_tgt_addr_q)], "write left byte invalid")
  `WBAB_ASSERT(a_wr_forwards,
               wr_en |=> (fwd_vld_q && (fwd_data_q == $past(alu_res.value))), "forward stale")

endmodule

`default_nettype wire
